>>> src/mfre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfre_pkg;

	// operation codes carried by the opcode field
	localparam logic [2:0] OP_POINT = 3'd0;
	localparam logic [2:0] OP_LINE  = 3'd1;
	localparam logic [2:0] OP_FILL  = 3'd2;
	localparam logic [2:0] OP_CLEAR = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;      // capture the accepted item
		logic rd;        // read the store at the current address
		logic wr;        // write back the modified byte of the current pixel
		logic adv;       // step to the next pixel of a line or fill
		logic clr;       // write zero at the sweep address and advance it
		logic out_load;  // load the result register
	} mfre_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic empty;     // fill covers no pixel
		logic last;      // current pixel is the last one of the item
		logic is_read;   // item is a byte read
		logic clr_last;  // sweep address is at the final entry
	} mfre_sts_t;

endpackage

`default_nettype wire

>>> src/mfre_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mfre_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        opcode,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output mfre_pkg::mfre_cmd_t    cmd,
	input  wire mfre_pkg::mfre_sts_t sts
);

	typedef enum logic [5:0] {
		S_INIT = 6'b000001,
		S_IDLE = 6'b000010,
		S_RD   = 6'b000100,
		S_WR   = 6'b001000,
		S_CLR  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (opcode) inside
						mfre_pkg::OP_POINT, mfre_pkg::OP_LINE,
						mfre_pkg::OP_FILL, mfre_pkg::OP_READ: begin
							state_d = S_RD;
						end
						mfre_pkg::OP_CLEAR: begin
							state_d = S_CLR;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_RD: begin
				if (sts.empty) begin
					state_d = S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = sts.is_read ? S_DONE : S_WR;
				end
			end
			S_WR: begin
				cmd.wr = 1'b1;
				if (sts.last) begin
					state_d = S_DONE;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_RD;
				end
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register, starts with the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> src/mfre_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module mfre_dpath #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [2:0]        opcode,
	input  wire logic [7:0]        x_start,
	input  wire logic [7:0]        y_start,
	input  wire logic [7:0]        x_end,
	input  wire logic [7:0]        y_end,
	input  wire logic [7:0]        width,
	input  wire logic [7:0]        height,
	input  wire logic              dot_value,
	input  wire logic [6:0]        read_column,
	input  wire logic [2:0]        read_page,
	output logic [7:0]             read_byte,
	input  wire mfre_pkg::mfre_cmd_t cmd,
	output mfre_pkg::mfre_sts_t    sts
);

	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int AW    = CW + PW;
	localparam int DEPTH = 1 << AW;
	localparam logic [8:0] COL_LIM  = 9'(COLUMNS);
	localparam logic [8:0] ROW_LIM  = 9'(PAGES * 8);
	localparam logic [4:0] PAGE_LIM = 5'(PAGES);
	localparam logic [4:0] PAGE_TOP = 5'(PAGES - 1);

	// pixel store, entry {column, page}
	logic [7:0] mem [DEPTH];

	logic [2:0]    op_q;
	logic          dot_q;
	logic [9:0]    cx_q;
	logic [9:0]    cy_q;
	logic [7:0]    dx_q;
	logic [7:0]    dy_q;
	logic          xneg_q;
	logic          yneg_q;
	logic [7:0]    span_q;
	logic [8:0]    ex_q;
	logic [8:0]    ey_q;
	logic [8:0]    k_q;
	logic [8:0]    right_q;
	logic [8:0]    bottom_q;
	logic [7:0]    top_q;
	logic          empty_q;
	logic [AW-1:0] rd_addr_q;
	logic          rd_ok_q;
	logic [AW-1:0] clr_cnt_q;
	logic [7:0]    rdata_q;
	logic [7:0]    read_byte_q;

	// load-time decode of the item
	logic [8:0] x9;
	logic [8:0] y9;
	logic [8:0] dxs;
	logic [8:0] dys;
	logic [7:0] dxm;
	logic [7:0] dym;
	logic [8:0] r_sum;
	logic [8:0] b_sum;
	logic [8:0] col9;
	logic [4:0] pg5;

	assign x9    = {1'b0, x_start};
	assign y9    = {1'b0, y_start};
	assign dxs   = {1'b0, x_end} - x9;
	assign dys   = {1'b0, y_end} - y9;
	assign dxm   = dxs[8] ? 8'(-dxs) : dxs[7:0];
	assign dym   = dys[8] ? 8'(-dys) : dys[7:0];
	assign r_sum = x9 + {1'b0, width};
	assign b_sum = y9 + {1'b0, height};
	assign col9  = {2'b00, read_column};
	assign pg5   = {2'b00, read_page};

	// current pixel address and mask
	logic          pix_ok;
	logic [4:0]    page_full;
	logic [AW-1:0] pix_addr;
	logic [7:0]    mask;
	logic          pix_on;
	logic [7:0]    mod_byte;

	assign pix_ok    = !cx_q[9] && (cx_q[8:0] < COL_LIM) && !cy_q[9] && (cy_q[8:0] < ROW_LIM);
	assign page_full = PAGE_TOP - {1'b0, cy_q[6:3]};
	assign pix_addr  = {cx_q[CW-1:0], page_full[PW-1:0]};
	assign mask      = 8'h80 >> cy_q[2:0];
	assign pix_on    = (op_q == mfre_pkg::OP_LINE) ? 1'b1 : dot_q;
	assign mod_byte  = pix_on ? (rdata_q | mask) : (rdata_q & ~mask);

	// line stepping
	logic [8:0] ex_sum;
	logic [8:0] ey_sum;
	logic       last_line;
	logic       last_fill;
	logic       row_end;

	assign ex_sum    = ex_q + {1'b0, dx_q};
	assign ey_sum    = ey_q + {1'b0, dy_q};
	assign last_line = (k_q == ({1'b0, span_q} + 9'd1));
	assign row_end   = ((cy_q[8:0] + 9'd1) == bottom_q);
	assign last_fill = ((cx_q[8:0] + 9'd1) == right_q) && row_end;

	// status
	always_comb begin
		sts          = '0;
		sts.empty    = empty_q;
		sts.is_read  = (op_q == mfre_pkg::OP_READ);
		sts.clr_last = &clr_cnt_q;
		unique case (op_q)
			mfre_pkg::OP_LINE: sts.last = last_line;
			mfre_pkg::OP_FILL: sts.last = last_fill;
			default:           sts.last = 1'b1;
		endcase
	end

	// store ports
	logic          mem_we;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;

	assign mem_we  = cmd.clr || (cmd.wr && pix_ok);
	assign wr_addr = cmd.clr ? clr_cnt_q : pix_addr;
	assign wr_data = cmd.clr ? 8'h00 : mod_byte;
	assign rd_addr = (op_q == mfre_pkg::OP_READ) ? rd_addr_q : pix_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// item capture and pixel stepping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			dot_q     <= dot_value;
			cx_q      <= {2'b00, x_start};
			cy_q      <= {2'b00, y_start};
			dx_q      <= dxm;
			dy_q      <= dym;
			xneg_q    <= dxs[8];
			yneg_q    <= dys[8];
			span_q    <= (dxm > dym) ? dxm : dym;
			ex_q      <= '0;
			ey_q      <= '0;
			k_q       <= '0;
			right_q   <= (r_sum > COL_LIM) ? COL_LIM : r_sum;
			bottom_q  <= (b_sum > ROW_LIM) ? ROW_LIM : b_sum;
			top_q     <= y_start;
			empty_q   <= (opcode == mfre_pkg::OP_FILL) &&
				((width == 8'd0) || (height == 8'd0) || (x9 >= COL_LIM) || (y9 >= ROW_LIM));
			rd_ok_q   <= (col9 < COL_LIM) && (pg5 < PAGE_LIM);
			rd_addr_q <= {col9[CW-1:0], pg5[PW-1:0]};
		end else if (cmd.adv) begin
			if (op_q == mfre_pkg::OP_FILL) begin
				if (row_end) begin
					cy_q <= {2'b00, top_q};
					cx_q <= cx_q + 10'd1;
				end else begin
					cy_q <= cy_q + 10'd1;
				end
			end else begin
				k_q <= k_q + 9'd1;
				if (ex_sum > {1'b0, span_q}) begin
					ex_q <= ex_sum - {1'b0, span_q};
					cx_q <= xneg_q ? (cx_q - 10'd1) : (cx_q + 10'd1);
				end else begin
					ex_q <= ex_sum;
				end
				if (ey_sum > {1'b0, span_q}) begin
					ey_q <= ey_sum - {1'b0, span_q};
					cy_q <= yneg_q ? (cy_q - 10'd1) : (cy_q + 10'd1);
				end else begin
					ey_q <= ey_sum;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_byte_q <= ((op_q == mfre_pkg::OP_READ) && rd_ok_q) ? rdata_q : 8'h00;
		end
	end

	assign read_byte = read_byte_q;

endmodule

`default_nettype wire

>>> src/mono_framebuffer_raster_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// One-bit frame buffer of COLUMNS x (8*PAGES) pixels held in a single-port
// byte store addressed {column, page}; pixel row y lives in page PAGES-1-y/8
// at bit 7-y%8. Every item returns one read_byte (the addressed byte for a
// read, zero otherwise). Each pixel costs one read-modify-write of the store.
// A point touches one pixel, a read makes one store read, a line steps
// through max(|dx|,|dy|)+2 pixels, a fill through w*h pixels after clipping
// (none when nothing is covered), unused opcodes touch no pixel, and
// clear-all writes zero to every entry of the store. A result that is held
// off by out_stall delays the next item. After reset the store is cleared
// by a sweep of all 2**(clog2(COLUMNS)+clog2(PAGES)) entries (1024 by default)
// during which no item is taken. A finished result waits in the output
// register while the next item is accepted.
module mono_framebuffer_raster_engine #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] opcode,
	input  wire logic [7:0] x_start,
	input  wire logic [7:0] y_start,
	input  wire logic [7:0] x_end,
	input  wire logic [7:0] y_end,
	input  wire logic [7:0] width,
	input  wire logic [7:0] height,
	input  wire logic       dot_value,
	input  wire logic [6:0] read_column,
	input  wire logic [2:0] read_page,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_byte
);

	mfre_pkg::mfre_cmd_t cmd;
	mfre_pkg::mfre_sts_t sts;

	// sequencing of each item
	mfre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// store, pixel stepping and result
	mfre_dpath #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (opcode),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.width       (width),
		.height      (height),
		.dot_value   (dot_value),
		.read_column (read_column),
		.read_page   (read_page),
		.read_byte   (read_byte),
		.cmd         (cmd),
		.sts         (sts)
	);

	// an accepted item holds off the next one until it is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous item still in work");

	// store port and capture commands never overlap
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd, cmd.wr, cmd.clr, cmd.out_load}))
		else $error("overlapping datapath commands");

	// a result is only loaded when the output register is free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid || !out_stall)
		else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

>>> test/tb_mono_framebuffer_raster_engine.sv
`timescale 1ns / 1ps

// panel geometry at the default parameters
localparam int FB_COLUMNS = 128;
localparam int FB_PAGES   = 8;
localparam int FB_ROWS    = FB_PAGES * 8;

// opcodes with no operation behind them
localparam logic [2:0] OP_SPARE_LO = 3'd5;
localparam logic [2:0] OP_SPARE_HI = 3'd7;

// one drawing command as presented on the input ports
typedef struct {
	logic [2:0] opcode;
	logic [7:0] x_start;
	logic [7:0] y_start;
	logic [7:0] x_end;
	logic [7:0] y_end;
	logic [7:0] width;
	logic [7:0] height;
	logic       dot_value;
	logic [6:0] read_column;
	logic [2:0] read_page;
} frame_cmd_t;

// shadow frame buffer plus the queue of read bytes still owed by the block
class raster_scoreboard;
	logic [7:0] frame_bytes [FB_COLUMNS * FB_PAGES];
	logic [7:0] expected_bytes [$];
	int failures;

	function new();
		foreach (frame_bytes[i])
			frame_bytes[i] = 8'h00;
		failures = 0;
	endfunction

	// set or clear one pixel, dropping anything off the panel
	function void plot(int x, int y, bit on);
		int page;
		int idx;
		logic [7:0] mask;
		if (x < 0 || y < 0 || x >= FB_COLUMNS || y >= FB_ROWS)
			return;
		page = FB_PAGES - 1 - y / 8;
		mask = 8'h80 >> (y % 8);
		idx = x * FB_PAGES + page;
		if (on)
			frame_bytes[idx] = frame_bytes[idx] | mask;
		else
			frame_bytes[idx] = frame_bytes[idx] & ~mask;
	endfunction

	// error-accumulation stepping, span+2 points so the start is hit twice
	function void draw_line(int x0, int y0, int x1, int y1);
		int dx, dy, sx, sy, ex, ey, span, cx, cy, k;
		dx = x1 - x0;
		dy = y1 - y0;
		sx = 0;
		sy = 0;
		ex = 0;
		ey = 0;
		cx = x0;
		cy = y0;
		if (dx > 0) begin
			sx = 1;
		end else if (dx < 0) begin
			sx = -1;
			dx = -dx;
		end
		if (dy > 0) begin
			sy = 1;
		end else if (dy < 0) begin
			sy = -1;
			dy = -dy;
		end
		span = (dx > dy) ? dx : dy;
		for (k = 0; k <= span + 1; k++) begin
			plot(cx, cy, 1'b1);
			ex += dx;
			ey += dy;
			if (ex > span) begin
				ex -= span;
				cx += sx;
			end
			if (ey > span) begin
				ey -= span;
				cy += sy;
			end
		end
	endfunction

	// rectangle with right and bottom clipped to the panel
	function void fill_rect(int left, int top, int w, int h, bit on);
		int right, bottom, i, j;
		right = left + w;
		bottom = top + h;
		if (right > FB_COLUMNS)
			right = FB_COLUMNS;
		if (bottom > FB_ROWS)
			bottom = FB_ROWS;
		for (i = left; i < right; i++)
			for (j = top; j < bottom; j++)
				plot(i, j, on);
	endfunction

	// apply an accepted command and queue the byte it must return
	function void note_command(frame_cmd_t c);
		logic [7:0] owed;
		owed = 8'h00;
		case (c.opcode)
			mfre_pkg::OP_POINT: plot(int'(c.x_start), int'(c.y_start), c.dot_value);
			mfre_pkg::OP_LINE: draw_line(int'(c.x_start), int'(c.y_start),
				int'(c.x_end), int'(c.y_end));
			mfre_pkg::OP_FILL: fill_rect(int'(c.x_start), int'(c.y_start), int'(c.width),
				int'(c.height), c.dot_value);
			mfre_pkg::OP_CLEAR: begin
				foreach (frame_bytes[i])
					frame_bytes[i] = 8'h00;
			end
			mfre_pkg::OP_READ:
				owed = frame_bytes[int'(c.read_column) * FB_PAGES + int'(c.read_page)];
			default: ;
		endcase
		expected_bytes.push_back(owed);
	endfunction

	// compare a delivered byte with the oldest one owed
	function void check_read_byte(logic [7:0] got);
		logic [7:0] want;
		if (expected_bytes.size() == 0) begin
			$error("read_byte: result with no item pending, expected none, actual %02h", got);
			failures++;
			return;
		end
		want = expected_bytes.pop_front();
		if (got !== want) begin
			$error("read_byte: expected %02h, actual %02h", want, got);
			failures++;
		end
	endfunction
endclass

module tb_mono_framebuffer_raster_engine;

	localparam int CLK_PERIOD       = 20;
	localparam int RESET_CYCLES     = 9;
	localparam int RANDOM_PER_PHASE = 470;
	localparam int BACKLOG_ITEMS    = 24;
	localparam int HOLD_CYCLES      = 300;
	localparam int DRAIN_CYCLES     = 20;

	typedef enum int {
		PH_DIRECTED,
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH,
		PH_BACKLOG
	} test_phase_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] opcode;
	logic [7:0] x_start;
	logic [7:0] y_start;
	logic [7:0] x_end;
	logic [7:0] y_end;
	logic [7:0] width;
	logic [7:0] height;
	logic       dot_value;
	logic [6:0] read_column;
	logic [2:0] read_page;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_byte;

	raster_scoreboard sb;
	test_phase_t phase = PH_DIRECTED;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	mono_framebuffer_raster_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.width(width),
		.height(height),
		.dot_value(dot_value),
		.read_column(read_column),
		.read_page(read_page),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_byte(read_byte)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// build a command from plain field values
	function automatic frame_cmd_t make_command(logic [2:0] op, int xs, int ys, int xe, int ye,
		int w, int h, bit dot, int col, int pg);
		frame_cmd_t c;
		c.opcode = op;
		c.x_start = 8'(xs);
		c.y_start = 8'(ys);
		c.x_end = 8'(xe);
		c.y_end = 8'(ye);
		c.width = 8'(w);
		c.height = 8'(h);
		c.dot_value = dot;
		c.read_column = 7'(col);
		c.read_page = 3'(pg);
		return c;
	endfunction

	// random command, mostly on-panel and cheap, some full-range coordinates
	function automatic frame_cmd_t random_command();
		frame_cmd_t c;
		int pick;
		c.opcode = mfre_pkg::OP_READ;
		c.x_start = 8'($urandom);
		c.y_start = 8'($urandom);
		c.x_end = 8'($urandom);
		c.y_end = 8'($urandom);
		c.width = 8'($urandom);
		c.height = 8'($urandom);
		c.dot_value = 1'($urandom);
		c.read_column = 7'($urandom);
		c.read_page = 3'($urandom);
		pick = $urandom_range(99);
		if (pick < 24) begin
			c.opcode = mfre_pkg::OP_POINT;
			if ($urandom_range(9) < 7) begin
				c.x_start = 8'($urandom_range(FB_COLUMNS - 1));
				c.y_start = 8'($urandom_range(FB_ROWS - 1));
			end
		end else if (pick < 48) begin
			c.opcode = mfre_pkg::OP_LINE;
			if ($urandom_range(3) != 0) begin
				c.x_start = 8'($urandom_range(FB_COLUMNS - 1));
				c.y_start = 8'($urandom_range(FB_ROWS - 1));
				c.x_end = 8'($urandom_range(FB_COLUMNS - 1));
				c.y_end = 8'($urandom_range(FB_ROWS - 1));
			end
		end else if (pick < 66) begin
			c.opcode = mfre_pkg::OP_FILL;
			if ($urandom_range(3) != 0) begin
				c.x_start = 8'($urandom_range(FB_COLUMNS - 1));
				c.y_start = 8'($urandom_range(FB_ROWS - 1));
				c.width = 8'($urandom_range(16));
				c.height = 8'($urandom_range(16));
			end else begin
				// full-range size near the far corner, clipped to a small patch
				c.x_start = 8'($urandom_range(255, FB_COLUMNS - 16));
				c.y_start = 8'($urandom_range(255, FB_ROWS - 16));
			end
		end else if (pick < 68) begin
			c.opcode = mfre_pkg::OP_CLEAR;
		end else if (pick < 71) begin
			c.opcode = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
		end
		return c;
	endfunction

	// present one item, hold it until taken, leave at the next falling edge
	task automatic drive_command(input frame_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = c.opcode;
		x_start = c.x_start;
		y_start = c.y_start;
		x_end = c.x_end;
		y_end = c.y_end;
		width = c.width;
		height = c.height;
		dot_value = c.dot_value;
		read_column = c.read_column;
		read_page = c.read_page;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_command(c);
		@(negedge clk);
	endtask

	task automatic run_random(input test_phase_t ph, input int idle_pct, input int stall_pct,
		input int count);
		phase = ph;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			drive_command(random_command());
	endtask

	// corners, off-panel points, line shapes, clipped and empty fills
	task automatic run_directed();
		phase = PH_DIRECTED;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drive_command(make_command(mfre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 7));
		drive_command(make_command(mfre_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_POINT, 127, 63, 0, 0, 0, 0, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_POINT, 128, 10, 0, 0, 0, 0, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_POINT, 5, 64, 0, 0, 0, 0, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 7));
		drive_command(make_command(mfre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 127, 0));
		drive_command(make_command(mfre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 6));
		drive_command(make_command(mfre_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// line colour ignores dot_value
		drive_command(make_command(mfre_pkg::OP_LINE, 0, 0, 127, 63, 0, 0, 0, 0, 0));
		drive_command(make_command(mfre_pkg::OP_LINE, 100, 50, 3, 2, 0, 0, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_LINE, 10, 0, 12, 63, 0, 0, 0, 0, 0));
		drive_command(make_command(mfre_pkg::OP_LINE, 20, 20, 20, 20, 0, 0, 0, 0, 0));
		drive_command(make_command(mfre_pkg::OP_LINE, 200, 10, 0, 255, 0, 0, 0, 0, 0));
		drive_command(make_command(mfre_pkg::OP_FILL, 0, 0, 0, 0, 128, 64, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 77, 3));
		drive_command(make_command(mfre_pkg::OP_FILL, 0, 0, 0, 0, 255, 255, 0, 0, 0));
		drive_command(make_command(mfre_pkg::OP_FILL, 10, 10, 0, 0, 0, 20, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_FILL, 10, 10, 0, 0, 20, 0, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_FILL, 250, 250, 0, 0, 255, 255, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_FILL, 120, 60, 0, 0, 255, 255, 1, 0, 0));
		drive_command(make_command(mfre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 127, 0));
		drive_command(make_command(mfre_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		drive_command(make_command(OP_SPARE_HI, 255, 255, 255, 255, 255, 255, 1, 127, 7));
		drive_command(make_command(mfre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 127, 0));
	endtask

	// cheap items back to back while the receiver holds off
	task automatic run_backlog();
		int n;
		phase = PH_BACKLOG;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (n = 0; n < BACKLOG_ITEMS; n++) begin
			if (n % 2 == 0)
				drive_command(make_command(mfre_pkg::OP_POINT, $urandom_range(FB_COLUMNS - 1),
					$urandom_range(FB_ROWS - 1), 0, 0, 0, 0, 1, 0, 0));
			else
				drive_command(make_command(mfre_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0,
					$urandom_range(FB_COLUMNS - 1), $urandom_range(FB_PAGES - 1)));
		end
	endtask

	// receiver: random stalls, one long hold-off during the backlog phase
	initial begin : receiver
		int hold_left;
		bit hold_done;
		out_stall = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (phase == PH_BACKLOG && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_read_byte(read_byte);
	end

	// main sequence
	initial begin : stimulus
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = mfre_pkg::OP_POINT;
		x_start = 8'h00;
		y_start = 8'h00;
		x_end = 8'h00;
		y_end = 8'h00;
		width = 8'h00;
		height = 8'h00;
		dot_value = 1'b0;
		read_column = 7'h00;
		read_page = 3'h0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_random(PH_FREE, 0, 0, RANDOM_PER_PHASE);
		run_backlog();
		run_random(PH_SEND_IDLE, 49, 0, RANDOM_PER_PHASE);
		run_random(PH_RECV_STALL, 0, 49, RANDOM_PER_PHASE);
		run_random(PH_BOTH, 10, 10, RANDOM_PER_PHASE);
		in_valid = 1'b0;

		// drain outstanding results, then watch for strays
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		#100ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
